[hdl/bchc_pkg.sv]
// ----------------------------------------------------------------------------
// bchc_pkg
// Shared types, sizes and codes of the two-hand clock block cache controller.
// ----------------------------------------------------------------------------
package bchc_pkg;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned SLOT_W       = $clog2(SLOTS);
  localparam int unsigned BLK_W        = 31;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned SWEEP_START  = 9;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  // result codes
  localparam logic [KIND_W-1:0] KIND_WRITE_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILL        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE_THRU  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_DONE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE_DONE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLUSH_DONE  = 3'd5;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [BLK_W-1:0]  blk_t;

  // request from the sequencer to the tag store
  typedef struct packed {
    logic      we;
    slot_idx_t waddr;
    slot_idx_t raddr;
    blk_t      key;
  } tag_req_t;

  // step a hand or scan index around the ring of slots
  function automatic slot_idx_t slot_inc(input slot_idx_t s);
    slot_idx_t r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

[hdl/bchc_tag_store.sv]
// ----------------------------------------------------------------------------
// bchc_tag_store
// Tag array of the cache slots with one write port, one registered read port
// and the single tag comparator that the lookup scan reuses every cycle.
// ----------------------------------------------------------------------------
module bchc_tag_store
  import bchc_pkg::*;
(
  input  logic     clk,
  input  tag_req_t req,
  output blk_t     rd_tag,
  output logic     match
);

  blk_t tags [SLOTS];

  // write the requested block into a slot on fill
  always_ff @(posedge clk) begin
    if (req.we) begin
      tags[req.waddr] <= req.key;
    end
  end

  // read one slot into a register ahead of its use
  always_ff @(posedge clk) begin
    rd_tag <= tags[req.raddr];
  end

  // compare the slot read last cycle against the request block
  assign match = (rd_tag == req.key);

endmodule

[hdl/block_cache_two_hand_clock_unit.sv]
// ----------------------------------------------------------------------------
// block_cache_two_hand_clock_unit
// Tag and policy controller of a fully associative write-back block cache
// with two-hand clock replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the final result word has been put out, and every result word
// appears for exactly one cycle with strobe high (last marks the final one).
// The lookup checks one slot per cycle through a single tag comparator. A
// read miss then steps the victim and sweep hands one slot per cycle until
// an unreferenced slot turns up (1 to 10 steps, since the sweep hand clears
// bits nine slots ahead of the slot the victim hand checks), followed by
// write-back, fill and done cycles. A flush scans all SLOTS slots, one per
// cycle, then puts out its done word. Func code 3 is taken and dropped
// without any result and without raising busy.
// ----------------------------------------------------------------------------
module block_cache_two_hand_clock_unit
  import bchc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [FUNC_W-1:0]       func,
  input  logic [BLK_W-1:0]        block_num,
  output logic                    busy,
  output logic                    strobe,
  output logic [KIND_W-1:0]       kind,
  output logic [BLK_W-1:0]        cmd_block,
  output logic [SLOT_FIELD_W-1:0] slot,
  output logic                    hit,
  output logic                    last,
  output logic [CNT_W-1:0]        read_total,
  output logic [CNT_W-1:0]        write_total,
  output logic [CNT_W-1:0]        hit_total,
  output logic [CNT_W-1:0]        miss_total
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_LOOKUP     = 4'd1;
  localparam logic [3:0] S_VICTIM     = 4'd2;
  localparam logic [3:0] S_WB         = 4'd3;
  localparam logic [3:0] S_FILL       = 4'd4;
  localparam logic [3:0] S_READ_DONE  = 4'd5;
  localparam logic [3:0] S_WRITE_DONE = 4'd6;
  localparam logic [3:0] S_FLUSH      = 4'd7;
  localparam logic [3:0] S_FLUSH_DONE = 4'd8;

  localparam slot_idx_t LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [3:0]        state;
  logic [FUNC_W-1:0] req_func;
  blk_t              req_blk;
  slot_idx_t         scan;
  slot_idx_t         victim_hand;
  slot_idx_t         sweep_hand;
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOTS-1:0]  slot_referenced;
  logic [SLOTS-1:0]  slot_dirty;
  logic [CNT_W-1:0]  read_count;
  logic [CNT_W-1:0]  write_count;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  miss_count;

  tag_req_t  tag_req;
  blk_t      rd_tag;
  logic      tag_match;
  logic      scan_hit;
  slot_idx_t victim_next;
  logic      victim_free;

  // drive the tag store: address the slot needed next cycle, since the
  // read is registered
  always_comb begin
    tag_req.we    = (state == S_FILL);
    tag_req.waddr = victim_hand;
    tag_req.key   = req_blk;
    case (state)
      S_IDLE:            tag_req.raddr = '0;
      S_LOOKUP, S_FLUSH: tag_req.raddr = slot_inc(scan);
      S_VICTIM:          tag_req.raddr = victim_next;
      default:           tag_req.raddr = scan;
    endcase
  end

  bchc_tag_store u_tags (
    .clk    (clk),
    .req    (tag_req),
    .rd_tag (rd_tag),
    .match  (tag_match)
  );

  assign scan_hit    = slot_valid[scan] && tag_match;
  assign victim_next = slot_inc(victim_hand);
  // the sweep hand clears its bit in the same step, so it counts as free
  assign victim_free = !slot_referenced[victim_next] || (sweep_hand == victim_next);

  assign busy        = (state != S_IDLE);
  assign read_total  = read_count;
  assign write_total = write_count;
  assign hit_total   = hit_count;
  assign miss_total  = miss_count;

  // sequencer, slot flags and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      strobe          <= 1'b0;
      scan            <= '0;
      victim_hand     <= LAST_SLOT;
      sweep_hand      <= SLOT_W'(SWEEP_START % SLOTS);
      slot_valid      <= '0;
      slot_referenced <= '0;
      slot_dirty      <= '0;
      read_count      <= '0;
      write_count     <= '0;
      hit_count       <= '0;
      miss_count      <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_func <= func;
            req_blk  <= block_num;
            scan     <= '0;
            case (func)
              FUNC_READ: begin
                read_count <= read_count + 1'b1;
                state      <= S_LOOKUP;
              end
              FUNC_WRITE: begin
                write_count <= write_count + 1'b1;
                state       <= S_LOOKUP;
              end
              FUNC_FLUSH: state <= S_FLUSH;
              default:    state <= S_IDLE;
            endcase
          end
        end

        // compare one slot per cycle
        S_LOOKUP: begin
          if (scan_hit) begin
            hit_count             <= hit_count + 1'b1;
            slot_referenced[scan] <= 1'b1;
            if (req_func == FUNC_WRITE) begin
              slot_dirty[scan] <= 1'b1;
            end
            strobe    <= 1'b1;
            kind      <= (req_func == FUNC_WRITE) ? KIND_WRITE_DONE : KIND_READ_DONE;
            cmd_block <= req_blk;
            slot      <= SLOT_FIELD_W'(scan);
            hit       <= 1'b1;
            last      <= 1'b1;
            state     <= S_IDLE;
          end else if (scan == LAST_SLOT) begin
            miss_count <= miss_count + 1'b1;
            if (req_func == FUNC_WRITE) begin
              strobe    <= 1'b1;
              kind      <= KIND_WRITE_THRU;
              cmd_block <= req_blk;
              slot      <= '0;
              hit       <= 1'b0;
              last      <= 1'b0;
              state     <= S_WRITE_DONE;
            end else begin
              state <= S_VICTIM;
            end
          end else begin
            scan <= slot_inc(scan);
          end
        end

        // advance both hands one slot per cycle
        S_VICTIM: begin
          slot_referenced[sweep_hand] <= 1'b0;
          sweep_hand                  <= slot_inc(sweep_hand);
          victim_hand                 <= victim_next;
          if (victim_free) begin
            state <= S_WB;
          end
        end

        S_WB: begin
          if (slot_dirty[victim_hand] && slot_valid[victim_hand]) begin
            strobe    <= 1'b1;
            kind      <= KIND_WRITE_BACK;
            cmd_block <= rd_tag;
            slot      <= SLOT_FIELD_W'(victim_hand);
            hit       <= 1'b0;
            last      <= 1'b0;
          end
          state <= S_FILL;
        end

        S_FILL: begin
          slot_dirty[victim_hand]      <= 1'b0;
          slot_referenced[victim_hand] <= 1'b1;
          slot_valid[victim_hand]      <= 1'b1;
          strobe    <= 1'b1;
          kind      <= KIND_FILL;
          cmd_block <= req_blk;
          slot      <= SLOT_FIELD_W'(victim_hand);
          hit       <= 1'b0;
          last      <= 1'b0;
          state     <= S_READ_DONE;
        end

        S_READ_DONE: begin
          strobe    <= 1'b1;
          kind      <= KIND_READ_DONE;
          cmd_block <= req_blk;
          slot      <= SLOT_FIELD_W'(victim_hand);
          hit       <= 1'b0;
          last      <= 1'b1;
          state     <= S_IDLE;
        end

        S_WRITE_DONE: begin
          strobe    <= 1'b1;
          kind      <= KIND_WRITE_DONE;
          cmd_block <= req_blk;
          slot      <= '0;
          hit       <= 1'b0;
          last      <= 1'b1;
          state     <= S_IDLE;
        end

        // write back each valid dirty slot in ascending order
        S_FLUSH: begin
          if (slot_dirty[scan] && slot_valid[scan]) begin
            slot_dirty[scan] <= 1'b0;
            strobe    <= 1'b1;
            kind      <= KIND_WRITE_BACK;
            cmd_block <= rd_tag;
            slot      <= SLOT_FIELD_W'(scan);
            hit       <= 1'b0;
            last      <= 1'b0;
          end
          if (scan == LAST_SLOT) begin
            state <= S_FLUSH_DONE;
          end else begin
            scan <= slot_inc(scan);
          end
        end

        S_FLUSH_DONE: begin
          strobe    <= 1'b1;
          kind      <= KIND_FLUSH_DONE;
          cmd_block <= '0;
          slot      <= '0;
          hit       <= 1'b0;
          last      <= 1'b1;
          state     <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // the two hands keep a fixed distance around the ring
  localparam int unsigned HAND_GAP = ((SWEEP_START % SLOTS) + 1) % SLOTS;
  logic [SLOT_W:0] gap_sum;
  slot_idx_t       sweep_expect;
  assign gap_sum      = {1'b0, victim_hand} + (SLOT_W + 1)'(HAND_GAP);
  assign sweep_expect = (gap_sum >= (SLOT_W + 1)'(SLOTS)) ?
                        SLOT_W'(gap_sum - (SLOT_W + 1)'(SLOTS)) : SLOT_W'(gap_sum);

`ifndef NO_ASSERTIONS
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final result word while still busy");

  a_more_words: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result word after returning idle");

  a_hand_gap: assert property (@(posedge clk) disable iff (rst)
    sweep_hand == sweep_expect)
    else $error("sweep hand lost its distance to the victim hand");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_FILL |-> slot_valid[victim_hand] && busy)
    else $error("fill word without a valid victim slot");
`endif

endmodule
